FILE: rtl/pvu_pkg.sv
// ----------------------------------------------------------------------------
// pvu_pkg
// Shared widths and limits of the population variance unit.
// ----------------------------------------------------------------------------
package pvu_pkg;

  // Q8.8 sample and its square
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;

  // Q16.16 variance result; the quotient never exceeds 2^30
  localparam int VAR_W   = 31;
  localparam int QUOT_W  = 31;
  localparam logic [VAR_W-1:0] VAR_MAX = VAR_W'(32'h4000_0000);

  // Extra bits of the sum, sum of squares and magnitude over the count width
  localparam int SUM_XW   = SAMPLE_W;
  localparam int SUMSQ_XW = 30;
  localparam int MAG_XW   = 15;

endpackage

FILE: rtl/pvu_front.sv
// ----------------------------------------------------------------------------
// pvu_front
// Sample accumulator: sums samples and squares, counts them, flags drops and
// hands a snapshot of the run to the queue on the last beat.
// ----------------------------------------------------------------------------
module pvu_front #(
  parameter int MAX_SAMPLES = 4096,
  parameter int CNT_W       = 13,
  parameter int SUM_W       = 29,
  parameter int SUM_SQ_W    = 43
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [pvu_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         last_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output logic signed [SUM_W-1:0]      snap_sum_o,
  output logic [SUM_SQ_W-1:0]          snap_sum_sq_o,
  output logic [CNT_W-1:0]             snap_count_o,
  output logic                         snap_drop_o
);
  import pvu_pkg::*;

  logic signed [SUM_W-1:0]      sum_q, sum_d;
  logic [SUM_SQ_W-1:0]          sum_sq_q, sum_sq_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         drop_q, drop_d;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic [SQ_W-1:0]              sq;
  logic                         accept;
  logic                         room;

  // Hold every beat while the queue has no slot for a snapshot
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign room       = count_q < CNT_W'(MAX_SAMPLES);

  assign prod = sample_i * sample_i;
  assign sq   = prod[SQ_W-1:0];

  always_comb begin
    sum_d    = sum_q;
    sum_sq_d = sum_sq_q;
    count_d  = count_q;
    drop_d   = drop_q;
    if (room) begin
      sum_d    = sum_q + SUM_W'(sample_i);
      sum_sq_d = sum_sq_q + SUM_SQ_W'(sq);
      count_d  = count_q + CNT_W'(1);
    end else begin
      drop_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      sum_sq_q <= '0;
      count_q  <= '0;
      drop_q   <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        // clear for the next run
        sum_q    <= '0;
        sum_sq_q <= '0;
        count_q  <= '0;
        drop_q   <= 1'b0;
      end else begin
        sum_q    <= sum_d;
        sum_sq_q <= sum_sq_d;
        count_q  <= count_d;
        drop_q   <= drop_d;
      end
    end
  end

  assign push_o        = accept & last_i;
  assign snap_sum_o    = sum_d;
  assign snap_sum_sq_o = sum_sq_d;
  assign snap_count_o  = count_d;
  assign snap_drop_o   = drop_d;

endmodule

FILE: rtl/pvu_queue.sv
// ----------------------------------------------------------------------------
// pvu_queue
// Two-entry FIFO of run snapshots between the accumulator and the divider.
// ----------------------------------------------------------------------------
module pvu_queue #(
  parameter int DATA_W = 86
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);
  import pvu_pkg::*;

  logic [DATA_W-1:0] entry_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: rtl/pvu_back.sv
// ----------------------------------------------------------------------------
// pvu_back
// Variance engine: shift-add products n*sum_sq, sum^2 and n*n, then a
// restoring divider, one bit per cycle, into the output register.
// ----------------------------------------------------------------------------
module pvu_back #(
  parameter int CNT_W    = 13,
  parameter int SUM_W    = 29,
  parameter int SUM_SQ_W = 43
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  logic signed [SUM_W-1:0]       snap_sum_i,
  input  logic [SUM_SQ_W-1:0]           snap_sum_sq_i,
  input  logic [CNT_W-1:0]              snap_count_i,
  input  logic                          snap_drop_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pvu_pkg::VAR_W-1:0]     variance_out_o,
  output logic [CNT_W-1:0]              sample_count_o,
  output logic                          overflowed_o
);
  import pvu_pkg::*;

  localparam int MAG_W   = CNT_W + MAG_XW;
  localparam int NUM_W   = 2 * CNT_W + SUMSQ_XW;
  localparam int DEN_W   = 2 * CNT_W;
  localparam int DCNT_W  = $clog2(QUOT_W);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;
  localparam logic [2:0] ST_MUL_B = 3'd2;
  localparam logic [2:0] ST_MUL_D = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]         state_q;
  logic               out_valid_q;
  logic [DCNT_W-1:0]  div_cnt_q;

  logic [NUM_W-1:0]   acc_q, mcand_q, prod_q, num_q;
  logic [MAG_W-1:0]   mplier_q, mag_q;
  logic [CNT_W-1:0]   n_q;
  logic               drop_q;
  logic [DEN_W-1:0]   den_q, rem_q;
  logic [QUOT_W-1:0]  low_q, quot_q;
  logic [VAR_W-1:0]   var_q;
  logic [CNT_W-1:0]   cnt_out_q;
  logic               ovf_q;

  logic               mul_done;
  logic [NUM_W-1:0]   acc_step;
  logic [MAG_W-1:0]   snap_mag;
  logic [SUM_W-1:0]   snap_neg;
  logic [DEN_W:0]     trial, trial_diff;
  logic               trial_ge;
  logic               out_load;

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign snap_neg = -snap_sum_i;
  assign snap_mag = snap_sum_i[SUM_W-1] ? snap_neg[MAG_W-1:0] : snap_sum_i[MAG_W-1:0];

  assign mul_done = mplier_q == '0;
  assign acc_step = mplier_q[0] ? acc_q + mcand_q : acc_q;

  assign trial      = {rem_q, low_q[QUOT_W-1]};
  assign trial_ge   = trial >= {1'b0, den_q};
  assign trial_diff = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:  if (q_valid_i) state_q <= ST_MUL_A;
        ST_MUL_A: if (mul_done) state_q <= ST_MUL_B;
        ST_MUL_B: if (mul_done) state_q <= ST_MUL_D;
        ST_MUL_D: if (mul_done) state_q <= ST_DIV;
        ST_DIV:   if (div_cnt_q == '0) state_q <= ST_OUT;
        ST_OUT:   if (out_load) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          acc_q    <= '0;
          mcand_q  <= NUM_W'(snap_sum_sq_i);
          mplier_q <= MAG_W'(snap_count_i);
          mag_q    <= snap_mag;
          n_q      <= snap_count_i;
          drop_q   <= snap_drop_i;
        end
      end
      ST_MUL_A, ST_MUL_B, ST_MUL_D: begin
        if (mul_done) begin
          acc_q <= '0;
          if (state_q == ST_MUL_A) begin
            prod_q   <= acc_q;
            mcand_q  <= NUM_W'(mag_q);
            mplier_q <= mag_q;
          end else if (state_q == ST_MUL_B) begin
            // clamp a negative numerator to zero
            num_q    <= (acc_q <= prod_q) ? prod_q - acc_q : '0;
            mcand_q  <= NUM_W'(n_q);
            mplier_q <= MAG_W'(n_q);
          end else begin
            den_q     <= acc_q[DEN_W-1:0];
            // upper numerator bits are already below the divisor
            rem_q     <= DEN_W'(num_q[NUM_W-1:QUOT_W]);
            low_q     <= num_q[QUOT_W-1:0];
            quot_q    <= '0;
            div_cnt_q <= DCNT_W'(QUOT_W - 1);
          end
        end else begin
          acc_q    <= acc_step;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      ST_DIV: begin
        rem_q     <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quot_q    <= {quot_q[QUOT_W-2:0], trial_ge};
        low_q     <= low_q << 1;
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
      end
      ST_OUT: begin
        if (out_load) begin
          var_q     <= (quot_q > VAR_MAX) ? VAR_MAX : quot_q;
          cnt_out_q <= n_q;
          ovf_q     <= drop_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign variance_out_o = var_q;
  assign sample_count_o = cnt_out_q;
  assign overflowed_o   = ovf_q;

endmodule

FILE: rtl/population_variance_unit.sv
// ----------------------------------------------------------------------------
// population_variance_unit
// Population variance of runs of Q8.8 samples, Q16.16 result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample a beat with
//   last_i on the final sample of a run. The accumulator takes one beat per
//   cycle while not stalled. Beats past MAX_SAMPLES in a run are dropped
//   and flagged. Output channel (out_valid_o / out_stall_i) carries one
//   result per run: variance_out_o, sample_count_o and overflowed_o.
//   From the last beat, the result follows shift-add products bounded by
//   the bit lengths of n and |sum|, then 31 divide steps. The divider
//   handles one run at a time; a two-entry snapshot queue lets the next
//   runs accumulate meanwhile, so the input stalls only when two finished
//   runs wait for the divider.
//   A stalled output holds its result; the divider finishes the next run and
//   waits for the output register to free.
//   Reset clears the run accumulators, the queue and the output valid.
// ----------------------------------------------------------------------------
module population_variance_unit #(
  parameter int MAX_SAMPLES = 4096,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [pvu_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pvu_pkg::VAR_W-1:0]         variance_out_o,
  output logic [CNT_W-1:0]                  sample_count_o,
  output logic                              overflowed_o
);
  import pvu_pkg::*;

  localparam int SUM_W    = CNT_W + SUM_XW;
  localparam int SUM_SQ_W = CNT_W + SUMSQ_XW;
  localparam int SNAP_W   = 1 + CNT_W + SUM_SQ_W + SUM_W;

  logic                    push;
  logic                    q_full, q_valid, q_pop;
  logic signed [SUM_W-1:0] f_sum;
  logic [SUM_SQ_W-1:0]     f_sum_sq;
  logic [CNT_W-1:0]        f_count;
  logic                    f_drop;
  logic [SNAP_W-1:0]       q_wdata, q_rdata;
  logic signed [SUM_W-1:0] b_sum;
  logic [SUM_SQ_W-1:0]     b_sum_sq;
  logic [CNT_W-1:0]        b_count;
  logic                    b_drop;

  pvu_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .SUM_SQ_W   (SUM_SQ_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .snap_sum_o   (f_sum),
    .snap_sum_sq_o(f_sum_sq),
    .snap_count_o (f_count),
    .snap_drop_o  (f_drop)
  );

  assign q_wdata = {f_drop, f_count, f_sum_sq, f_sum};

  pvu_queue #(
    .DATA_W(SNAP_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign {b_drop, b_count, b_sum_sq, b_sum} = q_rdata;

  pvu_back #(
    .CNT_W   (CNT_W),
    .SUM_W   (SUM_W),
    .SUM_SQ_W(SUM_SQ_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .snap_sum_i    (b_sum),
    .snap_sum_sq_i (b_sum_sq),
    .snap_count_i  (b_count),
    .snap_drop_i   (b_drop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .variance_out_o(variance_out_o),
    .sample_count_o(sample_count_o),
    .overflowed_o  (overflowed_o)
  );

  // A stalled input means two finished runs wait in the queue
  a_stall_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid)
    else $error("input stalled with no run queued");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0)
    else $error("result with empty run");

  a_var_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> variance_out_o <= VAR_MAX)
    else $error("variance above range");

  a_pop_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("divider took two runs back to back");

endmodule

FILE: tb/sv/variance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variance_checker
// Watches both channels of the population variance unit. It accumulates every
// accepted sample beat into its own run sums and works out the variance,
// count and overflow flag due at each run end. It then compares each result
// beat, field by field, with the oldest run still waiting.
// ----------------------------------------------------------------------------
module variance_checker #(
  parameter int MAX_SAMPLES = 4096,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [pvu_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [pvu_pkg::VAR_W-1:0]           variance_i,
  input  logic [CNT_W-1:0]                    count_i,
  input  logic                                overflowed_i,
  output int                                  mismatch_count_o,
  output int                                  runs_pending_o
);
  import pvu_pkg::*;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic [CNT_W-1:0] count;
    logic             overflowed;
  } run_result_t;

  run_result_t       expected_runs[$];
  longint            acc_sum;
  longint unsigned   acc_sum_sq;
  int unsigned       acc_count;
  logic              acc_dropped;
  int                mismatches;

  task automatic clear_run();
    acc_sum     = 0;
    acc_sum_sq  = 0;
    acc_count   = 0;
    acc_dropped = 1'b0;
  endtask

  // floor((n*sum_sq - sum^2) / n^2), clamped at 2^30
  function automatic run_result_t run_variance();
    run_result_t     r;
    longint unsigned n;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned sq;
    longint unsigned q;
    n   = acc_count;
    mag = (acc_sum < 0) ? -acc_sum : acc_sum;
    num = n * acc_sum_sq;
    sq  = mag * mag;
    num = (num >= sq) ? num - sq : 64'd0;
    q   = (n != 0) ? num / (n * n) : 64'd0;
    if (q > VAR_MAX) q = VAR_MAX;
    r.variance   = q[VAR_W-1:0];
    r.count      = n[CNT_W-1:0];
    r.overflowed = acc_dropped;
    return r;
  endfunction

  task automatic take_sample();
    longint s;
    s = sample_i;
    // drop beats once the run is full, the last one included
    if (acc_count < MAX_SAMPLES) begin
      acc_sum    += s;
      acc_sum_sq += s * s;
      acc_count++;
    end else begin
      acc_dropped = 1'b1;
    end
    if (last_i) begin
      expected_runs.push_back(run_variance());
      clear_run();
    end
  endtask

  task automatic check_result();
    run_result_t want;
    if (expected_runs.size() == 0) begin
      $error("result beat with no run pending: variance_out %0d sample_count %0d",
             variance_i, count_i);
      mismatches++;
    end else begin
      want = expected_runs.pop_front();
      if (variance_i !== want.variance) begin
        $error("variance_out: expected %0d, actual %0d", want.variance, variance_i);
        mismatches++;
      end
      if (count_i !== want.count) begin
        $error("sample_count: expected %0d, actual %0d", want.count, count_i);
        mismatches++;
      end
      if (overflowed_i !== want.overflowed) begin
        $error("overflowed: expected %0d, actual %0d", want.overflowed, overflowed_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_run();
      expected_runs.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && !in_stall_i) take_sample();
      if (out_valid_i && !out_stall_i) check_result();
    end
    mismatch_count_o <= mismatches;
    runs_pending_o   <= expected_runs.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the population variance unit. It sends a few
// directed runs (extremes, single samples, floored fractions), then random
// runs of mixed length and spread. Both channels idle at random, and a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import pvu_pkg::*;

  localparam int MAX_SAMPLES  = 4096;
  localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 150;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef enum {SPREAD_WIDE, SPREAD_EXTREME, SPREAD_CLUSTER, SPREAD_FLAT} spread_e;

  localparam sample_t SAMPLE_MIN = sample_t'(16'sh8000);
  localparam sample_t SAMPLE_MAX = sample_t'(16'sh7FFF);

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  sample_t          sample_i;
  logic             last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [VAR_W-1:0] variance_out_o;
  logic [CNT_W-1:0] sample_count_o;
  logic             overflowed_o;

  int mismatch_count;
  int runs_pending;
  int in_calm;

  population_variance_unit #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .variance_out_o(variance_out_o),
    .sample_count_o(sample_count_o),
    .overflowed_o  (overflowed_o)
  );

  variance_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .sample_i        (sample_i),
    .last_i          (last_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .variance_i      (variance_out_o),
    .count_i         (sample_count_o),
    .overflowed_i    (overflowed_o),
    .mismatch_count_o(mismatch_count),
    .runs_pending_o  (runs_pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Wait cycles before the next beat; now and then a stretch with none at all
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 60);
    return $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 17);
  endfunction

  function automatic sample_t pick_sample(spread_e spread, sample_t base);
    case (spread)
      SPREAD_EXTREME: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      SPREAD_CLUSTER: return base + sample_t'($urandom_range(0, 6)) - sample_t'(3);
      SPREAD_FLAT:    return base;
      default:        return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(input sample_t s, input logic l);
    int gap;
    gap = draw_wait(in_calm);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_run(input int run_len);
    spread_e spread;
    sample_t base;
    spread = spread_e'($urandom_range(0, 3));
    base   = sample_t'($urandom);
    for (int i = 1; i <= run_len; i++) send_beat(pick_sample(spread, base), i == run_len);
  endtask

  initial begin : stall_driver
    int calm;
    int hold;
    calm        = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait(calm);
      repeat (hold) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int sent;
    int run_len;
    in_calm    = 0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    last_i     = 1'b0;
    rst_ni     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-sample runs: n = 1, variance 0
    send_beat(SAMPLE_MAX, 1'b1);
    send_beat(SAMPLE_MIN, 1'b1);
    send_beat(sample_t'(0), 1'b1);
    // widest spread of two samples
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MAX, 1'b1);
    // flat run
    send_beat(sample_t'(0), 1'b0);
    send_beat(sample_t'(0), 1'b0);
    send_beat(sample_t'(0), 1'b1);
    // small fractions that floor
    send_beat(sample_t'(1), 1'b0);
    send_beat(sample_t'(2), 1'b1);
    send_beat(sample_t'(1), 1'b0);
    send_beat(sample_t'(-1), 1'b1);
    send_beat(sample_t'(1), 1'b0);
    send_beat(sample_t'(2), 1'b0);
    send_beat(sample_t'(4), 1'b1);
    // extremes, alternating
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MAX, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:       run_len = $urandom_range(1, 4);
        8, 9, 10, 11, 12, 13, 14, 15: run_len = $urandom_range(5, 16);
        16, 17, 18:                   run_len = $urandom_range(17, 64);
        default:                      run_len = $urandom_range(65, 200);
      endcase
      send_random_run(run_len);
      sent += run_len;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (runs_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
